// ===== rtl/sue_pkg.sv =====
// sue_pkg: shared constants, codes and helper functions for the stereo upmix
// with downward expander. No dependencies; imported by the top level, the port
// checker and the testbench.
`default_nettype none

package sue_pkg;

    localparam int SAMPLE_BITS_DEF = 32;
    localparam int Q_BITS          = 31;

    // Q1.31 gains for -6 dB and -2 dB
    localparam logic [30:0] G6_Q31 = 31'd1076291389;
    localparam logic [30:0] G2_Q31 = 31'd1705806895;
    localparam logic [31:0] ONE_Q30 = 32'd1073741824;

    // mix_mode codes
    localparam logic [1:0] MODE_STEREO   = 2'd0;
    localparam logic [1:0] MODE_SURROUND = 2'd1;
    localparam logic [1:0] MODE_FIVE     = 2'd2;

    // channels_valid codes
    localparam logic [1:0] CH_FRONT    = 2'd0;
    localparam logic [1:0] CH_SURROUND = 2'd1;
    localparam logic [1:0] CH_ALL      = 2'd2;

    // register indexes
    localparam logic [2:0] REG_MIX_MODE  = 3'd0;
    localparam logic [2:0] REG_KNEE_SOFT = 3'd1;
    localparam logic [2:0] REG_THRESHOLD = 3'd2;
    localparam logic [2:0] REG_RATIO     = 3'd3;
    localparam logic [2:0] REG_IN_GAIN   = 3'd4;
    localparam logic [2:0] REG_HEADROOM  = 3'd5;
    localparam logic [2:0] REG_ENABLE    = 3'd6;

    // reset values
    localparam logic [1:0]  RST_MIX_MODE  = MODE_SURROUND;
    localparam logic [30:0] RST_THRESHOLD = 31'd214748365;
    localparam logic [31:0] RST_RATIO     = 32'd966367642;
    localparam logic [30:0] RST_GAIN      = 31'd1076291389;

    // expander region of one sample
    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_ZERO,
        KIND_POS,
        KIND_NEG
    } kind_t;

    // saturate to Q1.31
    function automatic logic [31:0] sat32(input logic signed [39:0] v);
        logic [31:0] res;
        if (v > 40'sd2147483647) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -40'sd2147483648) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    // one restoring division step: returns {remainder, quotient bit}
    function automatic logic [31:0] div_step(input logic [30:0] rem,
                                             input logic       nbit,
                                             input logic [30:0] dvs);
        logic [31:0] sh;
        logic [31:0] diff;
        logic        ge;
        sh   = {rem, nbit};
        diff = sh - {1'b0, dvs};
        ge   = (sh >= {1'b0, dvs});
        return ge ? {diff[30:0], 1'b1} : {sh[30:0], 1'b0};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/stereo_upmix_with_expander.sv =====
// stereo_upmix_with_expander: top level, pipelined datapath, coefficient
// sequencer, APB register file and output skid stage.
// Depends on sue_pkg.
//
// Usage:
//  s_ channel: one stereo Q1.31 frame per transaction (left low, right high).
//  m_ channel: five Q1.31 samples per transaction in m_tdata, the
//   channels_valid code in m_tuser.
//  APB port: seven registers at byte addresses 0, 4, .. 24; used bits read
//   back as written. The user must write only while the stream is idle;
//   the block does not enforce it. Throughput: one frame per cycle while
//   s_tready is high. The 31 stages of the pipelined soft-knee quotient
//   make up most of the pipeline.
//  Coefficients: after reset and after every register write a sequencer
//   runs a multiply state, a setup state and two 64-step restoring
//   divisions; s_tready stays low during that run.
//  Stall: the pipeline drains into the output register and a one-entry
//   skid buffer; once the skid entry is full, the whole pipeline and
//   s_tready hold until m_tready frees it. Nothing is lost or repeated.
//  Reset: aresetn low clears all valid bits, reloads register defaults
//   and starts the coefficient run.
`default_nettype none

module stereo_upmix_with_expander import sue_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [63:0]  s_tdata,   // left_sample, right_sample
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [159:0]      m_tdata,   // out_left, out_right, out_center,
                                         // out_left_surround, out_right_surround
    output logic [1:0]        m_tuser,   // channels_valid
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int NS        = 37;
    localparam int DIV_FIRST = 3;
    localparam int DIV_LAST  = DIV_FIRST + Q_BITS - 1;
    localparam int ST_KQ     = DIV_LAST + 1;
    localparam int ST_G      = ST_KQ + 1;
    localparam int ST_RES    = ST_G + 1;
    localparam logic [31:0] KEEP_MASK = ~((32'd1 << (32 - SAMPLE_BITS)) - 32'd1);

    typedef struct packed {
        logic [1:0][31:0] x;
        kind_t [1:0]      kind;
        logic [1:0][35:0] hard;
        logic [32:0]      mix;
        logic [33:0]      cen;
    } side_t;

    typedef struct packed {
        logic [1:0]  chv;
        logic [31:0] rs;
        logic [31:0] ls;
        logic [31:0] c;
        logic [31:0] r;
        logic [31:0] l;
    } res_t;

    typedef enum logic [2:0] {
        DS_IDLE,
        DS_MULT,
        DS_SETUP,
        DS_DIV_HZ,
        DS_DIV_SZ
    } drv_state_t;

    // ---------------- registers ----------------
    logic [1:0]  mix_mode_reg;
    logic        knee_soft_reg;
    logic [30:0] threshold_reg;
    logic [31:0] ratio_reg;
    logic [30:0] in_gain_reg;
    logic [30:0] headroom_reg;
    logic        enable_reg;

    logic cfg_wr;
    logic cfg_hit;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_hit = cfg_wr && (paddr[4:2] <= REG_ENABLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mix_mode_reg  <= RST_MIX_MODE;
            knee_soft_reg <= 1'b0;
            threshold_reg <= RST_THRESHOLD;
            ratio_reg     <= RST_RATIO;
            in_gain_reg   <= RST_GAIN;
            headroom_reg  <= RST_GAIN;
            enable_reg    <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                REG_MIX_MODE:  mix_mode_reg  <= pwdata[1:0];
                REG_KNEE_SOFT: knee_soft_reg <= pwdata[0];
                REG_THRESHOLD: threshold_reg <= pwdata[30:0];
                REG_RATIO:     ratio_reg     <= pwdata;
                REG_IN_GAIN:   in_gain_reg   <= pwdata[30:0];
                REG_HEADROOM:  headroom_reg  <= pwdata[30:0];
                REG_ENABLE:    enable_reg    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_MIX_MODE:  prdata = {30'd0, mix_mode_reg};
            REG_KNEE_SOFT: prdata = {31'd0, knee_soft_reg};
            REG_THRESHOLD: prdata = {1'b0, threshold_reg};
            REG_RATIO:     prdata = ratio_reg;
            REG_IN_GAIN:   prdata = {1'b0, in_gain_reg};
            REG_HEADROOM:  prdata = {1'b0, headroom_reg};
            REG_ENABLE:    prdata = {31'd0, enable_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // ---------------- coefficient sequencer ----------------
    drv_state_t  ds_reg;
    logic [5:0]  dv_cnt_reg;
    logic [63:0] dv_dvd_reg;
    logic [32:0] dv_dvs_reg;
    logic [32:0] dv_rem_reg;
    logic [63:0] dv_q_reg;
    logic [61:0] hgp_reg;
    logic [63:0] rr_reg;
    logic [62:0] tr_reg;
    logic [30:0] hg_reg;
    logic signed [31:0] k_reg;
    logic        active_reg;
    logic [30:0] hz_reg;
    logic [30:0] sz_reg;

    logic [33:0] d_rem_sh;
    logic [33:0] d_diff;
    logic        d_ge;
    logic [32:0] d_rem_next;
    logic [63:0] d_q_next;
    logic [62:0] hg_rnd;
    logic [31:0] r2_w;
    logic [31:0] ratio_m1;
    logic        busy;

    always_comb begin
        d_rem_sh   = {dv_rem_reg, dv_dvd_reg[63]};
        d_diff     = d_rem_sh - {1'b0, dv_dvs_reg};
        d_ge       = (d_rem_sh >= {1'b0, dv_dvs_reg});
        d_rem_next = d_ge ? d_diff[32:0] : d_rem_sh[32:0];
        d_q_next   = {dv_q_reg[62:0], d_ge};
        hg_rnd     = {1'b0, hgp_reg} + 63'd1073741824;
        r2_w       = ({1'b0, rr_reg[63:33]} + 32'd1) >> 1;
        ratio_m1   = ratio_reg - ONE_Q30;
    end

    assign busy = (ds_reg != DS_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ds_reg     <= DS_MULT;
            dv_cnt_reg <= 6'd0;
        end else if (cfg_hit) begin
            ds_reg <= DS_MULT;
        end else begin
            case (ds_reg)
                DS_MULT: begin
                    hgp_reg <= 62'(headroom_reg * G6_Q31);
                    rr_reg  <= ratio_reg * ratio_reg;
                    tr_reg  <= 63'(threshold_reg * ratio_m1);
                    ds_reg  <= DS_SETUP;
                end
                DS_SETUP: begin
                    hg_reg     <= hg_rnd[61:31];
                    k_reg      <= 32'sd67108864 - $signed(r2_w);
                    active_reg <= (threshold_reg != 31'd0) && (ratio_reg != ONE_Q30);
                    dv_dvd_reg <= {3'd0, threshold_reg, 30'd0};
                    dv_dvs_reg <= {1'b0, ratio_reg};
                    dv_rem_reg <= 33'd0;
                    dv_q_reg   <= 64'd0;
                    dv_cnt_reg <= 6'd0;
                    ds_reg     <= DS_DIV_HZ;
                end
                DS_DIV_HZ: begin
                    dv_dvd_reg <= dv_dvd_reg << 1;
                    dv_rem_reg <= d_rem_next;
                    dv_q_reg   <= d_q_next;
                    dv_cnt_reg <= dv_cnt_reg + 6'd1;
                    if (dv_cnt_reg == 6'd63) begin
                        if (ratio_reg == 32'd0 || d_q_next >= {33'd0, threshold_reg}) begin
                            hz_reg <= 31'd0;
                        end else begin
                            hz_reg <= threshold_reg - d_q_next[30:0];
                        end
                        dv_dvd_reg <= {1'b0, tr_reg};
                        dv_dvs_reg <= {1'b0, ratio_reg} + {1'b0, ONE_Q30};
                        dv_rem_reg <= 33'd0;
                        dv_q_reg   <= 64'd0;
                        ds_reg     <= DS_DIV_SZ;
                    end
                end
                DS_DIV_SZ: begin
                    dv_dvd_reg <= dv_dvd_reg << 1;
                    dv_rem_reg <= d_rem_next;
                    dv_q_reg   <= d_q_next;
                    dv_cnt_reg <= dv_cnt_reg + 6'd1;
                    if (dv_cnt_reg == 6'd63) begin
                        sz_reg <= (ratio_reg > ONE_Q30) ? d_q_next[30:0] : 31'd0;
                        ds_reg <= DS_IDLE;
                    end
                end
                default: ds_reg <= DS_IDLE;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic [NS-1:0] vld_reg;
    logic          skid_valid_reg;
    logic          m_valid_reg;
    logic          en;
    logic          s_fire;
    logic          push;

    assign en       = !skid_valid_reg;
    assign s_tready = en && !busy;
    assign s_fire   = s_tvalid && s_tready;
    assign push     = en && vld_reg[ST_RES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], s_fire};
        end
    end

    // ---------------- stage 0: input gain ----------------
    logic signed [31:0] l0_reg [2];
    logic signed [31:0] xin [2];
    logic signed [63:0] p0 [2];
    logic signed [63:0] p0r [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            xin[i] = $signed(s_tdata[32*i +: 32]);
            p0[i]  = xin[i] * $signed({1'b0, in_gain_reg});
            p0r[i] = p0[i] + 64'sd1073741824;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 2; i++) begin
                l0_reg[i] <= enable_reg ? p0r[i][62:31] : xin[i];
            end
        end
    end

    // ---------------- stage 1: mix products, knee products ----------------
    logic signed [64:0] mixp1_reg;
    logic signed [64:0] cenp1_reg;
    logic signed [31:0] x1_reg [2];
    kind_t              kind1_reg [2];
    logic signed [66:0] hp1_reg [2];
    logic [61:0]        sq1_reg [2];

    logic signed [32:0] sum1;
    logic signed [32:0] xs [2];
    logic signed [32:0] ts;
    logic signed [32:0] zs;
    logic signed [33:0] dd [2];
    logic signed [67:0] sqf [2];
    logic               pos_w [2];
    logic               neg_w [2];
    logic               zero_w [2];
    kind_t              kind_w [2];

    always_comb begin
        sum1 = $signed({l0_reg[0][31], l0_reg[0]}) + $signed({l0_reg[1][31], l0_reg[1]});
        ts   = $signed({2'b00, threshold_reg});
        zs   = $signed({2'b00, knee_soft_reg ? sz_reg : hz_reg});
        for (int i = 0; i < 2; i++) begin
            xs[i]     = $signed({l0_reg[i][31], l0_reg[i]});
            pos_w[i]  = active_reg && (xs[i] < ts) && (xs[i] > zs);
            zero_w[i] = active_reg && (((xs[i] <= zs) && (xs[i] > 33'sd0))
                        || ((xs[i] >= -zs) && (xs[i] < 33'sd0)));
            neg_w[i]  = active_reg && (xs[i] > -ts) && (xs[i] < -zs);
            if (pos_w[i]) begin
                kind_w[i] = KIND_POS;
            end else if (zero_w[i]) begin
                kind_w[i] = KIND_ZERO;
            end else if (neg_w[i]) begin
                kind_w[i] = KIND_NEG;
            end else begin
                kind_w[i] = KIND_PASS;
            end
            dd[i]  = pos_w[i] ? (xs[i] - ts) : (xs[i] + ts);
            sqf[i] = dd[i] * dd[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mixp1_reg <= sum1 * $signed({1'b0, hg_reg});
            cenp1_reg <= sum1 * $signed({1'b0, headroom_reg});
            for (int i = 0; i < 2; i++) begin
                x1_reg[i]    <= l0_reg[i];
                kind1_reg[i] <= kind_w[i];
                hp1_reg[i]   <= $signed({1'b0, ratio_reg}) * dd[i];
                sq1_reg[i]   <= sqf[i][61:0];
            end
        end
    end

    // ---------------- stage 2: rounding, hard knee, quotient setup ----------------
    side_t       side_reg [2:ST_RES-1];
    logic [30:0] rem_reg [2:DIV_LAST][2];
    logic [30:0] num_reg [2:DIV_LAST][2];
    logic [30:0] q_reg   [2:DIV_LAST][2];

    logic signed [64:0] mixr;
    logic signed [64:0] cenr;
    logic signed [66:0] hrnd [2];
    logic signed [36:0] hsh [2];
    logic signed [36:0] hard_w [2];
    side_t              side2_w;

    always_comb begin
        mixr = mixp1_reg + 65'sd1073741824;
        cenr = cenp1_reg + 65'sd1073741824;
        side2_w.mix = mixr[63:31];
        side2_w.cen = cenr[64:31];
        for (int i = 0; i < 2; i++) begin
            hrnd[i] = hp1_reg[i] + 67'sd536870912;
            hsh[i]  = hrnd[i][66:30];
            if (kind1_reg[i] == KIND_NEG) begin
                hard_w[i] = hsh[i] - $signed({6'd0, threshold_reg});
            end else begin
                hard_w[i] = hsh[i] + $signed({6'd0, threshold_reg});
            end
            side2_w.x[i]    = x1_reg[i];
            side2_w.kind[i] = kind1_reg[i];
            side2_w.hard[i] = hard_w[i][35:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[2] <= side2_w;
            for (int i = 0; i < 2; i++) begin
                rem_reg[2][i] <= sq1_reg[i][61:31];
                num_reg[2][i] <= sq1_reg[i][30:0];
                q_reg[2][i]   <= '0;
            end
        end
    end

    // ---------------- stages 3..33: soft-knee quotient, one bit per stage ----------------
    logic [31:0] dstep [DIV_FIRST:DIV_LAST][2];

    always_comb begin
        for (int s = DIV_FIRST; s <= DIV_LAST; s++) begin
            for (int i = 0; i < 2; i++) begin
                dstep[s][i] = div_step(rem_reg[s-1][i], num_reg[s-1][i][Q_BITS-1],
                                       threshold_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = DIV_FIRST; s <= DIV_LAST; s++) begin
                side_reg[s] <= side_reg[s-1];
                for (int i = 0; i < 2; i++) begin
                    rem_reg[s][i] <= dstep[s][i][31:1];
                    num_reg[s][i] <= num_reg[s-1][i] << 1;
                    q_reg[s][i]   <= {q_reg[s-1][i][Q_BITS-2:0], dstep[s][i][0]};
                end
            end
        end
    end

    // ---------------- stage 34: k times quotient ----------------
    logic signed [63:0] kq_reg [2];

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[ST_KQ] <= side_reg[DIV_LAST];
            for (int i = 0; i < 2; i++) begin
                kq_reg[i] <= k_reg * $signed({1'b0, q_reg[DIV_LAST][i]});
            end
        end
    end

    // ---------------- stage 35: expander result times -2 dB ----------------
    logic signed [68:0] g_reg [2];
    logic signed [63:0] kqr [2];
    logic signed [35:0] adj [2];
    logic signed [36:0] soft_w [2];
    logic signed [36:0] e_w [2];
    logic signed [36:0] xe [2];

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            kqr[i] = kq_reg[i] + 64'sd134217728;
            adj[i] = kqr[i][63:28];
            xe[i]  = $signed(side_reg[ST_KQ].x[i]);
            if (side_reg[ST_KQ].kind[i] == KIND_NEG) begin
                soft_w[i] = xe[i] - adj[i];
            end else begin
                soft_w[i] = xe[i] + adj[i];
            end
            case (side_reg[ST_KQ].kind[i])
                KIND_ZERO: e_w[i] = '0;
                KIND_POS,
                KIND_NEG:  e_w[i] = knee_soft_reg ? soft_w[i]
                                    : $signed(side_reg[ST_KQ].hard[i]);
                default:   e_w[i] = xe[i];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[ST_G] <= side_reg[ST_KQ];
            for (int i = 0; i < 2; i++) begin
                g_reg[i] <= e_w[i] * $signed({1'b0, G2_Q31});
            end
        end
    end

    // ---------------- stage 36: add mix, saturate, channel select ----------------
    res_t               res_reg;
    res_t               res_w;
    logic signed [68:0] gr [2];
    logic signed [38:0] surr_w [2];
    logic [31:0]        surr_sat [2];
    logic [31:0]        mix_sat;
    logic [31:0]        cen_sat;
    logic               has_surr;

    always_comb begin
        for (int i = 0; i < 2; i++) begin
            gr[i]       = g_reg[i] + 69'sd1073741824;
            surr_w[i]   = $signed(gr[i][68:31]) + $signed(side_reg[ST_G].mix);
            surr_sat[i] = sat32(40'(surr_w[i]));
        end
        mix_sat  = sat32(40'($signed(side_reg[ST_G].mix)));
        cen_sat  = sat32(40'($signed(side_reg[ST_G].cen)));
        has_surr = (mix_mode_reg == MODE_SURROUND) || (mix_mode_reg == MODE_FIVE);
        res_w    = '0;
        if (!enable_reg) begin
            res_w.l   = side_reg[ST_G].x[0] & KEEP_MASK;
            res_w.r   = side_reg[ST_G].x[1] & KEEP_MASK;
            res_w.chv = CH_FRONT;
        end else begin
            res_w.l   = mix_sat & KEEP_MASK;
            res_w.r   = mix_sat & KEEP_MASK;
            res_w.chv = CH_FRONT;
            if (has_surr) begin
                res_w.ls  = surr_sat[0] & KEEP_MASK;
                res_w.rs  = surr_sat[1] & KEEP_MASK;
                res_w.chv = CH_SURROUND;
            end
            if (mix_mode_reg == MODE_FIVE) begin
                res_w.c   = cen_sat & KEEP_MASK;
                res_w.chv = CH_ALL;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_w;
        end
    end

    // ---------------- output register and skid entry ----------------
    res_t m_data_reg;
    res_t skid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_reg;
            end else if (push) begin
                m_data_reg <= res_reg;
            end
        end else if (push) begin
            skid_reg <= res_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_data_reg.rs, m_data_reg.ls, m_data_reg.c, m_data_reg.r, m_data_reg.l};
    assign m_tuser  = m_data_reg.chv;

endmodule

`default_nettype wire

// ===== rtl/sue_checker.sv =====
// sue_checker: port-level checks on the stereo upmix top level, attached by
// the bind statement at the end of this file. Depends on sue_pkg.
`default_nettype none

module sue_checker import sue_pkg::*; (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [159:0] m_tdata,
    input wire logic [1:0]   m_tuser
);

    // a stalled transaction holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // reset empties the pipeline and starts the coefficient run
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("not quiet after reset");

    // centre is only driven when all five channels are valid
    a_center: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != CH_ALL |-> m_tdata[95:64] == 32'd0)
        else $error("centre set outside five channel mode");

    // surround pair is zero for front-only results
    a_surr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == CH_FRONT |-> m_tdata[159:96] == 64'd0)
        else $error("surround set on front-only result");

    // with surround or all channels valid, both fronts carry the same mix
    a_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != CH_FRONT |-> m_tdata[31:0] == m_tdata[63:32])
        else $error("front pair differs");

endmodule

bind stereo_upmix_with_expander sue_checker u_sue_checker (.*);

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking testbench for stereo_upmix_with_expander, directed frames then
// randomized register settings and frames, scored against a fixed-point predictor.
// Depends on sue_pkg and the stereo_upmix_with_expander RTL.
`default_nettype none

module tb;
    import sue_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  RAND_SEGMENTS = 12;
    localparam int  SEG_FRAMES    = 52;
    localparam int  SETTLE_CYCLES = 60;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [1:0]   chans;
        logic [159:0] smp;   // left, right, center, left surround, right surround
    } frame_out_t;

    typedef struct {
        logic [31:0] left;
        logic [31:0] right;
    } frame_in_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [63:0]  s_tdata;   // left_sample, right_sample
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;   // out_left, out_right, out_center,
                             // out_left_surround, out_right_surround
    logic [1:0]   m_tuser;   // channels_valid
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    stereo_upmix_with_expander u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // register shadow and derived knee values
    logic [1:0]  mode_q;
    logic        soft_q;
    logic [30:0] thr_q;
    logic [31:0] ratio_q;
    logic [30:0] igain_q;
    logic [30:0] hgain_q;
    logic        enable_q;
    bit          xp_active;
    longint      hard_zero;
    longint      soft_zero;
    longint      knee_k;

    frame_out_t  upmix_q[$];
    int          errors;
    int          frames_sent;
    int          frames_checked;
    int          reg_writes;
    int          burst_left;
    longint      cycles;
    string       field_name[5] = '{"out_left", "out_right", "out_center",
                                   "out_left_surround", "out_right_surround"};

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t timeout with %0d frames outstanding", $time, upmix_q.size());
            $display("stereo_upmix_with_expander regression: fail");
            $finish;
        end
    end

    function automatic longint round_shift(input longint p, input int s);
        return (p + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic [31:0] clamp_q31(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic void update_knee();
        bit [63:0] t;
        bit [63:0] r;
        bit [63:0] q;
        bit [63:0] r2;
        t = {33'd0, thr_q};
        r = {32'd0, ratio_q};
        hard_zero = 0;
        soft_zero = 0;
        if (r != 0) begin
            q = (t << 30) / r;
            hard_zero = (q >= t) ? 0 : longint'(t - q);
        end
        if (r > {32'd0, ONE_Q30}) begin
            soft_zero = longint'((t * (r - ONE_Q30)) / (r + ONE_Q30));
        end
        r2 = (((r * r) >> 33) + 1) >> 1;
        knee_k = (longint'(1) << 26) - longint'(r2);
        xp_active = (t != 0) && (ratio_q != ONE_Q30);
    endfunction

    function automatic longint expand_sample(input longint x);
        longint t;
        longint r;
        longint z;
        longint d;
        if (!xp_active) begin
            return x;
        end
        t = longint'(thr_q);
        r = longint'(ratio_q);
        z = soft_q ? soft_zero : hard_zero;
        if (x < t && x > z) begin
            d = x - t;
            if (!soft_q) begin
                return t + round_shift(r * d, 30);
            end
            return x + round_shift(knee_k * ((d * d) / t), 28);
        end
        if ((x <= z && x > 0) || (x >= -z && x < 0)) begin
            return 0;
        end
        if (x > -t && x < -z) begin
            d = x + t;
            if (!soft_q) begin
                return -t + round_shift(r * d, 30);
            end
            return x - round_shift(knee_k * ((d * d) / t), 28);
        end
        return x;
    endfunction

    function automatic frame_out_t predict_upmix(input logic [31:0] lin, input logic [31:0] rin);
        frame_out_t o;
        longint     xl;
        longint     xr;
        longint     sum;
        longint     hg;
        longint     mix;
        xl = longint'(signed'(lin));
        xr = longint'(signed'(rin));
        o = '0;
        if (!enable_q) begin
            o.smp[31:0]  = lin;
            o.smp[63:32] = rin;
            o.chans      = CH_FRONT;
            return o;
        end
        xl  = round_shift(xl * longint'(igain_q), 31);
        xr  = round_shift(xr * longint'(igain_q), 31);
        sum = xl + xr;
        hg  = round_shift(longint'(hgain_q) * longint'(G6_Q31), 31);
        mix = round_shift(sum * hg, 31);
        o.smp[31:0]  = clamp_q31(mix);
        o.smp[63:32] = clamp_q31(mix);
        o.chans      = CH_FRONT;
        if (mode_q == MODE_SURROUND || mode_q == MODE_FIVE) begin
            o.smp[127:96]  = clamp_q31(round_shift(expand_sample(xl) * longint'(G2_Q31), 31) + mix);
            o.smp[159:128] = clamp_q31(round_shift(expand_sample(xr) * longint'(G2_Q31), 31) + mix);
            o.chans        = CH_SURROUND;
            if (mode_q == MODE_FIVE) begin
                o.smp[95:64] = clamp_q31(round_shift(sum * longint'(hgain_q), 31));
                o.chans      = CH_ALL;
            end
        end
        return o;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_MIX_MODE:  mode_q   = value[1:0];
            REG_KNEE_SOFT: soft_q   = value[0];
            REG_THRESHOLD: thr_q    = value[30:0];
            REG_RATIO:     ratio_q  = value;
            REG_IN_GAIN:   igain_q  = value[30:0];
            REG_HEADROOM:  hgain_q  = value[30:0];
            REG_ENABLE:    enable_q = value[0];
            default: ;
        endcase
        update_knee();
        reg_writes++;
    endtask

    // one stereo frame; want is used instead of the predictor when known
    task automatic send_frame(input logic [31:0] lin, input logic [31:0] rin,
                              input bit known, input frame_out_t want);
        int gap;
        s_tdata  = {rin, lin};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        upmix_q.push_back(known ? want : predict_upmix(lin, rin));
        frames_sent++;
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 16);
        end
    endtask

    // stream idle: every result back and the pipeline settled
    task automatic drain();
        s_tvalid = 1'b0;
        while (upmix_q.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h3FFF_FFFF);
            3: return -$urandom_range(0, 32'h3FFF_FFFF);
            4: return $urandom_range(0, 2 * thr_q + 2);
            5: return -$urandom_range(0, 2 * thr_q + 2);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_settings();
        reg_write(REG_MIX_MODE, $urandom_range(0, 3));
        reg_write(REG_KNEE_SOFT, $urandom_range(0, 1));
        case ($urandom_range(0, 4))
            0: reg_write(REG_THRESHOLD, 32'd0);
            1: reg_write(REG_THRESHOLD, 32'h7FFF_FFFF);
            2: reg_write(REG_THRESHOLD, $urandom);
            default: reg_write(REG_THRESHOLD, $urandom_range(1, 32'h2000_0000));
        endcase
        case ($urandom_range(0, 6))
            0: reg_write(REG_RATIO, 32'd0);
            1: reg_write(REG_RATIO, ONE_Q30);
            2: reg_write(REG_RATIO, 32'hFFFF_FFFF);
            3: reg_write(REG_RATIO, $urandom);
            default: reg_write(REG_RATIO, $urandom_range(32'h2000_0000, 32'h8000_0000));
        endcase
        case ($urandom_range(0, 3))
            0: reg_write(REG_IN_GAIN, 32'h7FFF_FFFF);
            1: reg_write(REG_IN_GAIN, 32'd0);
            default: reg_write(REG_IN_GAIN, $urandom);
        endcase
        case ($urandom_range(0, 3))
            0: reg_write(REG_HEADROOM, 32'h7FFF_FFFF);
            1: reg_write(REG_HEADROOM, 32'd0);
            default: reg_write(REG_HEADROOM, $urandom);
        endcase
        reg_write(REG_ENABLE, {31'd0, $urandom_range(0, 7) != 0});
    endtask

    // receiver stall pattern: a new character is drawn each time stall_cnt[5:0] returns to zero
    int unsigned stall_phase;
    int unsigned stall_cnt;
    always @(negedge aclk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt[5:0] == 0) begin
            stall_phase <= $urandom_range(0, 3);
        end
        case (stall_phase)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            2: m_tready <= (stall_cnt[1:0] == 0);
            default: m_tready <= $urandom_range(0, 7) != 0;
        endcase
    end

    always @(posedge aclk) begin
        frame_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (upmix_q.size() == 0) begin
                $display("%0t unexpected transaction: data %h chans %0d",
                         $time, m_tdata, m_tuser);
                errors++;
            end else begin
                want = upmix_q.pop_front();
                frames_checked++;
                for (int i = 0; i < 5; i++) begin
                    if (m_tdata[32*i +: 32] !== want.smp[32*i +: 32]) begin
                        $display("%0t %s mismatch: expected %h actual %h", $time,
                                 field_name[i], want.smp[32*i +: 32], m_tdata[32*i +: 32]);
                        errors++;
                    end
                end
                if (m_tuser !== want.chans) begin
                    $display("%0t channels_valid mismatch: expected %0d actual %0d",
                             $time, want.chans, m_tuser);
                    errors++;
                end
            end
        end
    end

    frame_in_t  corner_rows[] = '{
        '{32'h0000_0000, 32'h0000_0000}, '{32'h7FFF_FFFF, 32'h7FFF_FFFF},
        '{32'h8000_0000, 32'h8000_0000}, '{32'h7FFF_FFFF, 32'h8000_0000},
        '{32'h8000_0000, 32'h7FFF_FFFF}, '{32'h0000_0001, 32'hFFFF_FFFF},
        '{32'h1999_999A, 32'hE666_6666}, '{32'h1000_0000, 32'hF000_0000},
        '{32'h0400_0000, 32'hFC00_0000}, '{32'h3000_0000, 32'hD000_0000},
        '{32'h1800_0000, 32'hE800_0000}, '{32'h5555_5555, 32'hAAAA_AAAA}
    };
    frame_in_t  pass_rows[] = '{
        '{32'h7FFF_FFFF, 32'h8000_0000}, '{32'h8000_0000, 32'h7FFF_FFFF},
        '{32'h1234_5678, 32'hFEDC_BA98}
    };

    initial begin
        frame_out_t want;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        m_tready = 1'b0;
        stall_cnt = 0;
        stall_phase = 0;
        cycles = 0;
        errors = 0;
        frames_sent = 0;
        frames_checked = 0;
        reg_writes = 0;
        burst_left = 8;
        mode_q   = RST_MIX_MODE;
        soft_q   = 1'b0;
        thr_q    = RST_THRESHOLD;
        ratio_q  = RST_RATIO;
        igain_q  = RST_GAIN;
        hgain_q  = RST_GAIN;
        enable_q = 1'b1;
        update_knee();
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        // silence after reset in surround mode is all zero
        want = '0;
        want.chans = CH_SURROUND;
        send_frame(32'd0, 32'd0, 1'b1, want);
        foreach (corner_rows[i]) send_frame(corner_rows[i].left, corner_rows[i].right, 1'b0, want);
        drain();
        reg_write(REG_KNEE_SOFT, 32'd1);
        reg_write(REG_MIX_MODE, {30'd0, MODE_FIVE});
        foreach (corner_rows[i]) send_frame(corner_rows[i].left, corner_rows[i].right, 1'b0, want);
        drain();
        // expander bypassed by unity ratio, stereo mode, full gains
        reg_write(REG_RATIO, ONE_Q30);
        reg_write(REG_MIX_MODE, {30'd0, MODE_STEREO});
        reg_write(REG_IN_GAIN, 32'h7FFF_FFFF);
        reg_write(REG_HEADROOM, 32'h7FFF_FFFF);
        reg_write(REG_THRESHOLD, 32'h7FFF_FFFF);
        for (int i = 1; i < 5; i++) send_frame(corner_rows[i].left, corner_rows[i].right, 1'b0, want);
        drain();
        // pass through: inputs come back on the front pair
        reg_write(REG_ENABLE, 32'd0);
        foreach (pass_rows[i]) begin
            want = '0;
            want.smp[31:0]  = pass_rows[i].left;
            want.smp[63:32] = pass_rows[i].right;
            want.chans      = CH_FRONT;
            send_frame(pass_rows[i].left, pass_rows[i].right, 1'b1, want);
        end
        drain();
        reg_write(REG_ENABLE, 32'd1);

        for (int seg = 0; seg < RAND_SEGMENTS; seg++) begin
            random_settings();
            for (int n = 0; n < SEG_FRAMES; n++) begin
                send_frame(pick_sample(), pick_sample(), 1'b0, want);
            end
            drain();
        end

        $display("%0d frames sent, %0d checked over %0d register writes",
                 frames_sent, frames_checked, reg_writes);
        $display("covered all mix modes, hard and soft knee, bypass and pass-through, errors %0d",
                 errors);
        if (errors == 0) begin
            $display("stereo_upmix_with_expander regression: pass");
        end else begin
            $display("stereo_upmix_with_expander regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
